// File: src/mlfq_pkg.sv
`default_nettype none
package mlfq_pkg;

  localparam int TAG_W = 8;

  typedef enum logic [1:0] {
    CMD_NEW     = 2'd0,
    CMD_REQUEUE = 2'd1,
    CMD_SELECT  = 2'd2,
    CMD_CHECK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_CLAMP = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [TAG_W-1:0]  process_tag;
    logic [31:0]       now_time;
    logic [31:0]       selected_time;
    logic [15:0]       service_done;
    logic [15:0]       service_total;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [TAG_W-1:0]  picked_tag;
    logic [1:0]        picked_level;
    logic              keep_running;
    logic [6:0]        waiting_total;
  } out_t;

endpackage
`default_nettype wire

// File: src/mlfq_check.sv
`default_nettype none
module mlfq_check #(
  parameter int LVL_W = 2
) (
  input  wire logic [31:0]      now_time,
  input  wire logic [31:0]      selected_time,
  input  wire logic [15:0]      service_done,
  input  wire logic [15:0]      service_total,
  input  wire logic [LVL_W-1:0] level,
  input  wire logic             lowest,
  output logic                  keep_running
);

  logic [31:0] elapsed;
  logic [32:0] served;
  logic        finished;
  logic        in_slice;

  always_comb begin
    elapsed      = now_time - selected_time;
    served       = 33'(service_done) + 33'(elapsed);
    finished     = (served == 33'(service_total));
    in_slice     = ((elapsed >> level) == 32'd0);
    keep_running = !finished && (lowest || in_slice);
  end

endmodule
`default_nettype wire

// File: src/multilevel_feedback_scheduler.sv
// Multilevel feedback scheduler: LEVELS FIFO ready queues of process tags.
// Input channel (in_valid / in_stall / in_data) carries one command per
// transaction: insert new, insert requeue, select next or check running.
// Output channel (out_valid / out_stall / out_data) returns exactly one
// result transaction per command, in order.
// Path: a command accepted from in_data is captured in the input register,
// processed from there, and its result is registered in the result register
// that drives out_data. Throughput: one command per cycle unless stalled;
// each command touches at most one end of one queue in the tag memory (one
// write port, one registered read port) and a priority encode of level fills.
// Receiver stall: the result register holds; the input register holds its
// command and in_stall rises until the result is taken, so no transaction
// is lost. Queue state advances only when a command moves to the result.
// Reset: all queues empty, no level selected yet, both channels idle. The
// tag memory is not cleared; only written entries ever reach out_data.
`default_nettype none
module multilevel_feedback_scheduler #(
  parameter int LEVELS      = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire mlfq_pkg::in_t  in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output mlfq_pkg::out_t    out_data
);

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D  = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int CNT_W  = $clog2(MEM_D + 1);

  logic                   in_valid_r;
  mlfq_pkg::in_t          in_r;
  logic                   out_valid_r;
  mlfq_pkg::out_t         res_r, res_nxt;
  logic                   picked_r;
  logic [mlfq_pkg::TAG_W-1:0] tag_r;
  logic [mlfq_pkg::TAG_W-1:0] mem [MEM_D];

  logic [PTR_W-1:0]       heads_r [LEVELS];
  logic [PTR_W-1:0]       heads_nxt [LEVELS];
  logic [FILL_W-1:0]      fill_r [LEVELS];
  logic [FILL_W-1:0]      fill_nxt [LEVELS];
  logic [LVL_W-1:0]       cur_lvl_r, cur_lvl_nxt;
  logic                   lvl_valid_r, lvl_valid_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   adv;
  logic                   is_push;
  logic                   lowest;
  logic                   clamped;
  logic [LVL_W-1:0]       tgt;
  logic                   tgt_full;
  logic                   push_ok;
  logic                   found;
  logic [LVL_W-1:0]       sel_lvl;
  logic                   pop;
  logic [PTR_W-1:0]       wr_slot;
  logic [PTR_W-1:0]       rd_slot;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   keep;
  logic [LVL_W-1:0]       chk_lvl;
  logic [31:0]            cnt_ext;
  logic [31:0]            lvl_ext;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  assign lowest  = lvl_valid_r && (cur_lvl_r == LVL_W'(LEVELS - 1));
  assign chk_lvl = lvl_valid_r ? cur_lvl_r : '0;

  mlfq_check #(
    .LVL_W(LVL_W)
  ) u_check (
    .now_time     (in_r.now_time),
    .selected_time(in_r.selected_time),
    .service_done (in_r.service_done),
    .service_total(in_r.service_total),
    .level        (chk_lvl),
    .lowest       (lowest),
    .keep_running (keep)
  );

  always_comb begin
    logic [FILL_W:0] sum;
    is_push = (in_r.command == mlfq_pkg::CMD_NEW) || (in_r.command == mlfq_pkg::CMD_REQUEUE);
    clamped = (in_r.command == mlfq_pkg::CMD_REQUEUE) && lowest;
    tgt     = '0;
    if (in_r.command == mlfq_pkg::CMD_REQUEUE && lvl_valid_r) begin
      tgt = lowest ? LVL_W'(LEVELS - 1) : cur_lvl_r + LVL_W'(1);
    end

    tgt_full = 1'b0;
    wr_slot  = '0;
    found    = 1'b0;
    sel_lvl  = '0;
    for (int l = 0; l < LEVELS; l++) begin
      sum = (FILL_W + 1)'(heads_r[l]) + (FILL_W + 1)'(fill_r[l]);
      if (sum >= (FILL_W + 1)'(QUEUE_DEPTH)) begin
        sum = sum - (FILL_W + 1)'(QUEUE_DEPTH);
      end
      if (tgt == LVL_W'(l)) begin
        tgt_full = (fill_r[l] == FILL_W'(QUEUE_DEPTH));
        wr_slot  = PTR_W'(sum);
      end
    end
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (fill_r[l] != '0) begin
        found   = 1'b1;
        sel_lvl = LVL_W'(l);
      end
    end
    rd_slot = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (sel_lvl == LVL_W'(l)) begin
        rd_slot = heads_r[l];
      end
    end

    push_ok = is_push && !tgt_full;
    pop     = (in_r.command == mlfq_pkg::CMD_SELECT) && found;
    wr_addr = ADDR_W'(int'(tgt) * QUEUE_DEPTH + int'(wr_slot));
    rd_addr = ADDR_W'(int'(sel_lvl) * QUEUE_DEPTH + int'(rd_slot));

    for (int l = 0; l < LEVELS; l++) begin
      heads_nxt[l] = heads_r[l];
      fill_nxt[l]  = fill_r[l];
      if (push_ok && tgt == LVL_W'(l)) begin
        fill_nxt[l] = fill_r[l] + FILL_W'(1);
      end
      if (pop && sel_lvl == LVL_W'(l)) begin
        fill_nxt[l]  = fill_r[l] - FILL_W'(1);
        heads_nxt[l] = (heads_r[l] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : heads_r[l] + PTR_W'(1);
      end
    end

    cnt_nxt       = cnt_r;
    cur_lvl_nxt   = cur_lvl_r;
    lvl_valid_nxt = lvl_valid_r;
    if (push_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (pop) begin
      cnt_nxt       = cnt_r - CNT_W'(1);
      cur_lvl_nxt   = sel_lvl;
      lvl_valid_nxt = 1'b1;
    end

    cnt_ext = 32'(cnt_nxt);
    lvl_ext = 32'(sel_lvl);
    res_nxt = '0;
    res_nxt.status = mlfq_pkg::ST_OK;
    res_nxt.waiting_total = cnt_ext[6:0];
    unique case (in_r.command) inside
      mlfq_pkg::CMD_NEW, mlfq_pkg::CMD_REQUEUE: begin
        if (!push_ok) begin
          res_nxt.status = mlfq_pkg::ST_FULL;
        end else if (clamped) begin
          res_nxt.status = mlfq_pkg::ST_CLAMP;
        end
      end
      mlfq_pkg::CMD_SELECT: begin
        if (found) begin
          res_nxt.picked_level = lvl_ext[1:0];
        end else begin
          res_nxt.status = mlfq_pkg::ST_EMPTY;
        end
      end
      mlfq_pkg::CMD_CHECK: begin
        res_nxt.keep_running = keep;
      end
      default: begin
        res_nxt.status = mlfq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cur_lvl_r   <= '0;
      lvl_valid_r <= 1'b0;
      cnt_r       <= '0;
      picked_r    <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        heads_r[l] <= '0;
        fill_r[l]  <= '0;
      end
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        picked_r    <= pop;
        cur_lvl_r   <= cur_lvl_nxt;
        lvl_valid_r <= lvl_valid_nxt;
        cnt_r       <= cnt_nxt;
        for (int l = 0; l < LEVELS; l++) begin
          heads_r[l] <= heads_nxt[l];
          fill_r[l]  <= fill_nxt[l];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
    if (adv) begin
      res_r <= res_nxt;
      tag_r <= mem[rd_addr];
    end
    if (adv && push_ok) begin
      mem[wr_addr] <= in_r.process_tag;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data            = res_r;
    out_data.picked_tag = picked_r ? tag_r : '0;
  end

endmodule
`default_nettype wire

// File: src/mlfq_checker.sv
`default_nettype none
module mlfq_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire mlfq_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire mlfq_pkg::out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("command changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == mlfq_pkg::ST_EMPTY |->
      out_data.waiting_total == 7'd0 && out_data.picked_tag == '0)
    else $error("empty select with tags waiting");

  a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.keep_running || out_data.picked_tag != '0) |->
      out_data.status == mlfq_pkg::ST_OK && !(out_data.keep_running && out_data.picked_tag != '0))
    else $error("select and check fields both set");

endmodule

bind multilevel_feedback_scheduler mlfq_checker u_mlfq_checker (.*);
`default_nettype wire
